// ----- rtl/xpd_pkg.sv -----
// ----------------------------------------------------------------------------
// xpd_pkg
// Shared widths, the row record handed to the merge stage, and the popcount.
// ----------------------------------------------------------------------------
package xpd_pkg;

  localparam int LANES     = 4;
  localparam int MAX_WORDS = 128;
  localparam int WORD_W    = 64;

  localparam int BL_W   = 14;                               // bit_length register
  localparam int CNT_W  = $clog2(WORD_W + 1);               // popcount of one word
  localparam int SUM_W  = $clog2(MAX_WORDS * WORD_W + 1);   // lane sum
  localparam int WC_W   = $clog2(MAX_WORDS + 1);            // word counter
  localparam int DOT_W  = 16;
  localparam int CALC_W = ((SUM_W + 1 > BL_W) ? SUM_W + 1 : BL_W) + 3;
  localparam int PAD_SH = $clog2(2 * WORD_W);               // words * 2 * 64

  localparam int IN_W   = WORD_W * (LANES + 1);
  localparam int OUT_W  = DOT_W * LANES;

  localparam int BYTES  = WORD_W / 8;

  // configuration register indexes
  localparam logic CFG_BIT_LENGTH  = 1'b0;
  localparam logic CFG_PAD_CORRECT = 1'b1;

  localparam logic [BL_W-1:0] BIT_LENGTH_RST = BL_W'(64);

  typedef struct packed {
    logic [LANES-1:0][SUM_W-1:0] sums;
    logic [WC_W-1:0]             words;
    logic                        ovf;
  } row_t;

  // byte-wise counts, then a short sum over the bytes
  function automatic logic [CNT_W-1:0] popcount(input logic [WORD_W-1:0] x);
    logic [3:0]       bc;
    logic [CNT_W-1:0] total;
    total = '0;
    for (int b = 0; b < BYTES; b++) begin
      bc = '0;
      for (int i = 0; i < 8; i++) begin
        bc = bc + 4'(x[8*b + i]);
      end
      total = total + CNT_W'(bc);
    end
    return total;
  endfunction

endpackage

// ----- rtl/xpd_lane.sv -----
// ----------------------------------------------------------------------------
// xpd_lane
// One lane: XNOR popcount of the word pair and the running row sum.
// ----------------------------------------------------------------------------
module xpd_lane
  import xpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,    // transaction accepted
  input  logic              add_i,     // word counts towards the row
  input  logic              last_i,
  input  logic [WORD_W-1:0] act_i,
  input  logic [WORD_W-1:0] weight_i,
  output logic [SUM_W-1:0]  sum_o      // row sum including the current word
);

  logic [SUM_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] pc;

  assign pc    = popcount(~(act_i ^ weight_i));
  assign sum_o = add_i ? acc_q + SUM_W'(pc) : acc_q;

  always_comb begin
    acc_d = acc_q;
    if (take_i) begin
      acc_d = last_i ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- rtl/xpd_merge.sv -----
// ----------------------------------------------------------------------------
// xpd_merge
// Holds finished rows, scales the lane sums to sign dot products and drives
// the output register.
// ----------------------------------------------------------------------------
module xpd_merge
  import xpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BL_W-1:0]  bit_length_i,
  input  logic             pad_correct_i,
  input  logic             push_i,
  input  row_t             row_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o,
  output logic             out_ovf_o
);

  logic fin_valid_q, fin_valid_d;
  row_t fin_q;
  logic out_valid_q, out_valid_d;
  logic [OUT_W-1:0] dots_q;
  logic ovf_q;

  logic out_free, fin_adv;
  logic [OUT_W-1:0] dots_d;

  assign out_free = !out_valid_q || out_ready_i;
  assign fin_adv  = fin_valid_q && out_free;
  assign ready_o  = !fin_valid_q || fin_adv;

  // pad_correct: 2*sum - 128*words + bit_length, else 2*sum - bit_length
  always_comb begin
    logic signed [CALC_W-1:0] s2, bl, pad, r;
    bl  = $signed({{(CALC_W-BL_W){1'b0}}, bit_length_i});
    pad = $signed({{(CALC_W-WC_W){1'b0}}, fin_q.words}) <<< PAD_SH;
    for (int l = 0; l < LANES; l++) begin
      s2 = $signed({{(CALC_W-SUM_W-1){1'b0}}, fin_q.sums[l], 1'b0});
      r  = pad_correct_i ? s2 + bl - pad : s2 - bl;
      dots_d[DOT_W*l +: DOT_W] = r[DOT_W-1:0];
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (fin_adv) fin_valid_d = 1'b0;
    if (push_i)  fin_valid_d = 1'b1;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (fin_adv)     out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fin_q <= row_i;
    end
    if (fin_adv) begin
      dots_q <= dots_d;
      ovf_q  <= fin_q.ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = dots_q;
  assign out_ovf_o   = ovf_q;

endmodule

// ----- rtl/xnor_popcount_dot_lanes.sv -----
// ----------------------------------------------------------------------------
// xnor_popcount_dot_lanes
// Four-lane binary sign dot product with XNOR popcount accumulation.
// ----------------------------------------------------------------------------
// Takes one word transaction per cycle unless a stalled output holds the finishing
// register: every lane adds the XNOR popcount of its weight word and the
// activation word in the same cycle, and rows follow each other without a gap.
// On the word marked tlast the row sums move into a finishing register and the
// result passes on through the output register to the master side; up to two
// finished rows can wait in these registers while the output is stalled. Words
// beyond 128 in a row are dropped and flagged in m_axis_tuser. bit_length and
// pad_correct must only be written while no row is in flight.
module xnor_popcount_dot_lanes
  import xpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // act_word, weight_word_0, weight_word_1, weight_word_2, weight_word_3
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tlast,   // row_end
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // dot_0, dot_1, dot_2, dot_3
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tuser,   // overflow
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [BL_W-1:0]  cfg_wdata_i
);

  logic [BL_W-1:0] bit_length_q;
  logic            pad_correct_q;
  logic [WC_W-1:0] wc_q, wc_d;
  logic            ovf_q, ovf_d;

  logic take, sat, push;
  row_t row;

  assign take = s_axis_tvalid && s_axis_tready;
  assign sat  = (wc_q == WC_W'(MAX_WORDS));
  assign push = take && s_axis_tlast;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    xpd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .take_i   (take),
      .add_i    (!sat),
      .last_i   (s_axis_tlast),
      .act_i    (s_axis_tdata[WORD_W-1:0]),
      .weight_i (s_axis_tdata[WORD_W*(l+1) +: WORD_W]),
      .sum_o    (row.sums[l])
    );
  end

  assign row.words = sat ? wc_q : wc_q + WC_W'(1);
  assign row.ovf   = ovf_q || sat;

  always_comb begin
    wc_d  = wc_q;
    ovf_d = ovf_q;
    if (take) begin
      if (s_axis_tlast) begin
        wc_d  = '0;
        ovf_d = 1'b0;
      end else begin
        wc_d  = row.words;
        ovf_d = row.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q          <= '0;
      ovf_q         <= 1'b0;
      bit_length_q  <= BIT_LENGTH_RST;
      pad_correct_q <= 1'b0;
    end else begin
      wc_q  <= wc_d;
      ovf_q <= ovf_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BIT_LENGTH:  bit_length_q  <= cfg_wdata_i;
          CFG_PAD_CORRECT: pad_correct_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  xpd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bit_length_i  (bit_length_q),
    .pad_correct_i (pad_correct_q),
    .push_i        (push),
    .row_i         (row),
    .ready_o       (s_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_ovf_o     (m_axis_tuser)
  );

endmodule

// ----- tb/sv/xpd_dot_checker.sv -----
// ----------------------------------------------------------------------------
// xpd_dot_checker
// Watches the word and result streams and the register port of the four-lane
// XNOR popcount dot product, predicts every row result and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module xpd_dot_checker
  import xpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IN_W-1:0]  s_tdata_i,
  input  logic             s_tlast_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [OUT_W-1:0] m_tdata_i,
  input  logic             m_tuser_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [BL_W-1:0]  cfg_wdata_i,
  output int               mismatches_o,
  output int               rows_pending_o
);

  typedef struct packed {
    logic [LANES-1:0][DOT_W-1:0] dot;
    logic                        ovf;
  } dot_row_t;

  dot_row_t        expected_rows[$];
  logic [BL_W-1:0] bit_len;
  logic            pad_on;
  logic [13:0]     lane_sum[LANES];
  logic [7:0]      word_cnt;
  logic            ovf_seen;

  function automatic dot_row_t close_row();
    dot_row_t r;
    int       d;
    for (int l = 0; l < LANES; l++) begin
      d = 2 * int'(lane_sum[l]) - int'(bit_len);
      // pad correction: 2*(sum - (words*64 - bit_length)) - bit_length
      if (pad_on) d = d - 2 * WORD_W * int'(word_cnt) + 2 * int'(bit_len);
      r.dot[l] = DOT_W'(d);
    end
    r.ovf = ovf_seen;
    return r;
  endfunction

  task automatic flag(input string what, input logic [DOT_W-1:0] exp_v,
                      input logic [DOT_W-1:0] got_v);
    mismatches_o++;
    if (mismatches_o <= 10)
      $display("%0t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)", $realtime, what,
               $signed(exp_v), exp_v, $signed(got_v), got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dot_row_t          exp_row;
    logic [WORD_W-1:0] act;
    if (!rst_ni) begin
      bit_len  = BIT_LENGTH_RST;
      pad_on   = 1'b0;
      word_cnt = '0;
      ovf_seen = 1'b0;
      for (int l = 0; l < LANES; l++) lane_sum[l] = '0;
      expected_rows.delete();
      mismatches_o   = 0;
      rows_pending_o = 0;
    end else begin
      // result side first: a result never belongs to a word taken at this edge
      if (m_tvalid_i && m_tready_i) begin
        if (expected_rows.size() == 0) begin
          flag("unexpected result, dot_0", '0, m_tdata_i[DOT_W-1:0]);
        end else begin
          exp_row = expected_rows.pop_front();
          for (int l = 0; l < LANES; l++)
            if (m_tdata_i[DOT_W*l +: DOT_W] !== exp_row.dot[l])
              flag($sformatf("dot_%0d", l), exp_row.dot[l], m_tdata_i[DOT_W*l +: DOT_W]);
          if (m_tuser_i !== exp_row.ovf)
            flag("overflow", DOT_W'(exp_row.ovf), DOT_W'(m_tuser_i));
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        act = s_tdata_i[WORD_W-1:0];
        if (word_cnt >= MAX_WORDS) begin
          ovf_seen = 1'b1;  // word dropped, count saturated
        end else begin
          for (int l = 0; l < LANES; l++)
            lane_sum[l] = lane_sum[l]
                        + 14'($countones(~(act ^ s_tdata_i[WORD_W*(l+1) +: WORD_W])));
          word_cnt = word_cnt + 8'd1;
        end
        if (s_tlast_i) begin
          expected_rows.push_back(close_row());
          word_cnt = '0;
          ovf_seen = 1'b0;
          for (int l = 0; l < LANES; l++) lane_sum[l] = '0;
        end
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BIT_LENGTH:  bit_len = cfg_wdata_i;
          CFG_PAD_CORRECT: pad_on  = cfg_wdata_i[0];
          default: ;
        endcase
      end

      rows_pending_o = expected_rows.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the four-lane XNOR popcount dot product.
// ----------------------------------------------------------------------------
// Drives word rows through the slave stream under several bit_length and
// pad_correct settings, with random idling on both sides and one long output
// hold-off; the checker beside the block predicts and compares each result.
`timescale 1ns / 100ps

module tb;
  import xpd_pkg::*;

  localparam int HOLD_CYCLES = 250;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 215;

  logic             clk_i;
  logic             rst_ni;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             s_axis_tlast;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic             cfg_we_i;
  logic             cfg_addr_i;
  logic [BL_W-1:0]  cfg_wdata_i;

  int mismatches;
  int rows_pending;
  int words_sent;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;

  xnor_popcount_dot_lanes DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  xpd_dot_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tdata_i      (s_axis_tdata),
    .s_tlast_i      (s_axis_tlast),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatches_o   (mismatches),
    .rows_pending_o (rows_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic addr, input logic [BL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [BL_W-1:0] bl, input logic pad);
    write_reg(CFG_BIT_LENGTH, bl);
    write_reg(CFG_PAD_CORRECT, BL_W'(pad));
  endtask

  // all rows out, then a wait for anything still in the pipeline
  task automatic drain();
    do @(negedge clk_i); while (rows_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_word(input logic [IN_W-1:0] data, input logic last);
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_pattern(input logic [WORD_W-1:0] act,
                              input logic [LANES-1:0][WORD_W-1:0] w, input logic last);
    push_word({w, act}, last);
  endtask

  // weights equal or inverse to the activation, or one bit off it, push the lane sums to their extremes
  task automatic send_row(input int len);
    logic [WORD_W-1:0]              act;
    logic [LANES-1:0][WORD_W-1:0]   w;
    for (int i = 0; i < len; i++) begin
      act = rand_word();
      for (int l = 0; l < LANES; l++) begin
        case ($urandom_range(0, 4))
          0, 1:    w[l] = rand_word();
          2:       w[l] = act;
          3:       w[l] = ~act;
          default: w[l] = act ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
        endcase
      end
      send_pattern(act, w, i == len - 1);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 16);
    if (r < 99) return $urandom_range(17, MAX_WORDS);
    return $urandom_range(MAX_WORDS + 1, MAX_WORDS + 12);
  endfunction

  initial begin
    logic [BL_W-1:0]            bl;
    logic                       pad;
    int                         target;
    logic [LANES-1:0][WORD_W-1:0] edge_w;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_BIT_LENGTH;
    cfg_wdata_i   = '0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    hold_req      = 1'b0;
    words_sent    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, all-zero / all-one words against fixed weights
    edge_w = {{32{2'b10}}, {32{2'b01}}, {WORD_W{1'b1}}, {WORD_W{1'b0}}};
    send_pattern('0, edge_w, 1'b1);
    send_pattern('1, edge_w, 1'b1);
    send_row(3);
    s_axis_tvalid <= 1'b0;
    drain();

    // zero bit_length with pad correction: full match and full mismatch rows
    set_mode('0, 1'b1);
    send_pattern('1, {LANES{{WORD_W{1'b1}}}}, 1'b0);
    send_pattern('0, {LANES{{WORD_W{1'b0}}}}, 1'b1);
    send_pattern('1, {LANES{{WORD_W{1'b0}}}}, 1'b1);
    s_axis_tvalid <= 1'b0;
    drain();

    // bit_length at the top of the register, both modes
    set_mode('1, 1'b0);
    send_row(1);
    s_axis_tvalid <= 1'b0;
    drain();
    set_mode('1, 1'b1);
    send_row(2);
    s_axis_tvalid <= 1'b0;
    drain();
    set_mode(BL_W'(1), 1'b1);
    send_row(4);
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       begin bl = BL_W'(64);   pad = 1'b0; end
        1:       begin bl = BL_W'(8192); pad = 1'b1; end
        2:       begin bl = BL_W'(1);    pad = 1'b0; end
        3:       begin bl = '1;          pad = 1'b1; end
        default: begin bl = BL_W'($urandom_range(0, 16383)); pad = 1'($urandom); end
      endcase
      set_mode(bl, pad);
      tx_gaps = (p < PHASES - 1);
      rx_gaps = (p < PHASES - 1);
      target  = words_sent + PHASE_WORDS;
      if (p == 1) begin
        send_row(MAX_WORDS);       // exactly full, no overflow
        send_row(MAX_WORDS + 3);   // saturates and flags
      end
      if (p == 2) begin
        // output held off while single-word rows keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) send_row(1);
      end
      while (words_sent < target) send_row(pick_len());
      s_axis_tvalid <= 1'b0;
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/xpd_pkg.sv
rtl/xpd_lane.sv
rtl/xpd_merge.sv
rtl/xnor_popcount_dot_lanes.sv
tb/sv/xpd_dot_checker.sv
tb/sv/tb.sv
